// File: rtl/dpf_pkg.sv
// shared constants, state encoding and control/status bundles for the factoriser
`timescale 1ns / 1ps

package dpf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FACTOR_WIDTH    = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_START,
        ST_DIV,
        ST_DECIDE,
        ST_EMIT_PREV,
        ST_FINISH,
        ST_EMIT_REM
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic take_quot;
        logic inc_p;
        logic set_pend;
        logic clear_pend;
        logic push_pend;
        logic push_rem;
        logic push_none;
        logic push_last;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic p_gt_q;
        logic rem_zero;
        logic n_gt1;
        logic pend_valid;
        logic pend_same;
        logic out_free;
    } status_t;

endpackage

// File: rtl/dpf_in_if.sv
// input channel: one signed value per beat
`timescale 1ns / 1ps

interface dpf_in_if #(
    parameter int VALUE_WIDTH = dpf_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// File: rtl/dpf_out_if.sv
// output channel: one prime factor per beat with last and none-found flags
`timescale 1ns / 1ps

interface dpf_out_if;
    logic                              valid;
    logic                              ready;
    logic [dpf_pkg::FACTOR_WIDTH-1:0]  factor;
    logic                              last;
    logic                              none_found;

    modport source (output valid, output factor, output last, output none_found, input ready);
    modport sink   (input valid, input factor, input last, input none_found, output ready);
endinterface

// File: rtl/dpf_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module dpf_div #(
    parameter int VALUE_WIDTH = dpf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quot,
    output logic [VALUE_WIDTH-1:0] rem
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [VALUE_WIDTH:0]   rem_shift;
    logic [VALUE_WIDTH:0]   rem_sub;

    assign rem_shift = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign rem_sub   = rem_shift - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CW'(VALUE_WIDTH);
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift next dividend bit into the partial remainder
            if (!rem_sub[VALUE_WIDTH])
            begin
                rem_next  = rem_sub[VALUE_WIDTH-1:0];
                quot_next = {quot_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[VALUE_WIDTH-1:0];
                quot_next = {quot_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/dpf_datapath.sv
// datapath: magnitude, trial divisor, pending factor and output register
`timescale 1ns / 1ps

module dpf_datapath #(
    parameter int VALUE_WIDTH = dpf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpf_pkg::cmd_t                     cmd,
    output dpf_pkg::status_t                  status,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dpf_pkg::FACTOR_WIDTH-1:0]  out_factor,
    output logic                              out_last,
    output logic                              out_none_found
);

    localparam int FW = dpf_pkg::FACTOR_WIDTH;

    logic [VALUE_WIDTH-1:0] val_u;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] p_reg, p_next;
    logic [VALUE_WIDTH-1:0] pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FW-1:0]          out_factor_reg, out_factor_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_none_reg, out_none_next;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;
    logic                   out_free;

    assign val_u = value;
    // two's complement magnitude; the most negative value maps to 2^(w-1)
    assign mag   = val_u[VALUE_WIDTH-1] ? (~val_u + VALUE_WIDTH'(1)) : val_u;

    dpf_div #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .dividend(n_reg),
        .divisor (p_reg),
        .done    (div_done),
        .quot    (quot),
        .rem     (rem)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        n_next          = n_reg;
        p_next          = p_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (cmd.load)
        begin
            n_next          = mag;
            p_next          = VALUE_WIDTH'(2);
            pend_valid_next = 1'b0;
        end
        if (cmd.take_quot)
            n_next = quot;
        if (cmd.inc_p)
            p_next = p_reg + VALUE_WIDTH'(1);
        if (cmd.set_pend)
        begin
            pend_next       = p_reg;
            pend_valid_next = 1'b1;
        end
        if (cmd.clear_pend)
            pend_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_factor_next = out_factor_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.push_pend || cmd.push_rem || cmd.push_none)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.push_last;
            out_none_next  = cmd.push_none;
            if (cmd.push_none)
                out_factor_next = '0;
            else if (cmd.push_rem)
                out_factor_next = FW'(n_reg);
            else
                out_factor_next = FW'(pend_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        p_reg          <= p_next;
        pend_reg       <= pend_next;
        out_factor_reg <= out_factor_next;
        out_last_reg   <= out_last_next;
        out_none_reg   <= out_none_next;
    end

    assign status.div_done   = div_done;
    assign status.p_gt_q     = p_reg > quot;
    assign status.rem_zero   = rem == '0;
    assign status.n_gt1      = n_reg > VALUE_WIDTH'(1);
    assign status.pend_valid = pend_valid_reg;
    // divisor already held as the pending factor, so keep dividing it out
    assign status.pend_same  = pend_valid_reg && (pend_reg == p_reg);
    assign status.out_free   = out_free;

    assign out_valid      = out_valid_reg;
    assign out_factor     = out_factor_reg;
    assign out_last       = out_last_reg;
    assign out_none_found = out_none_reg;

endmodule

// File: rtl/dpf_ctrl.sv
// controller: sequences trial divisions and result beats
`timescale 1ns / 1ps

module dpf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dpf_pkg::status_t status,
    output dpf_pkg::cmd_t    cmd
);

    dpf_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpf_pkg::ST_IDLE:
                if (in_valid)
                    state_next = dpf_pkg::ST_CHECK;
            dpf_pkg::ST_CHECK:
                if (status.n_gt1)
                    state_next = dpf_pkg::ST_DIV;
                else if (status.out_free)
                    state_next = dpf_pkg::ST_IDLE;
            dpf_pkg::ST_START:
                state_next = dpf_pkg::ST_DIV;
            dpf_pkg::ST_DIV:
                if (status.div_done)
                    state_next = dpf_pkg::ST_DECIDE;
            dpf_pkg::ST_DECIDE:
                if (status.pend_same)
                    state_next = dpf_pkg::ST_START;
                else if (status.p_gt_q)
                    state_next = dpf_pkg::ST_FINISH;
                else if (status.rem_zero && status.pend_valid)
                    state_next = dpf_pkg::ST_EMIT_PREV;
                else
                    state_next = dpf_pkg::ST_START;
            dpf_pkg::ST_EMIT_PREV:
                if (status.out_free)
                    state_next = dpf_pkg::ST_START;
            dpf_pkg::ST_FINISH:
                if (status.n_gt1)
                begin
                    if (!status.pend_valid || status.out_free)
                        state_next = dpf_pkg::ST_EMIT_REM;
                end
                else if (status.out_free)
                    state_next = dpf_pkg::ST_IDLE;
            dpf_pkg::ST_EMIT_REM:
                if (status.out_free)
                    state_next = dpf_pkg::ST_IDLE;
            default:
                state_next = dpf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            dpf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            dpf_pkg::ST_CHECK:
                if (status.n_gt1)
                    cmd.div_start = 1'b1;
                else if (status.out_free)
                begin
                    cmd.push_none = 1'b1;
                    cmd.push_last = 1'b1;
                end
            dpf_pkg::ST_START:
                cmd.div_start = 1'b1;
            dpf_pkg::ST_DIV:
                cmd = '0;
            dpf_pkg::ST_DECIDE:
                if (status.pend_same)
                begin
                    cmd.take_quot = status.rem_zero;
                    cmd.inc_p     = !status.rem_zero;
                end
                else if (!status.p_gt_q)
                begin
                    if (!status.rem_zero)
                        cmd.inc_p = 1'b1;
                    else if (!status.pend_valid)
                    begin
                        cmd.set_pend  = 1'b1;
                        cmd.take_quot = 1'b1;
                    end
                end
            dpf_pkg::ST_EMIT_PREV:
                if (status.out_free)
                begin
                    // older factor leaves as the new one takes its place
                    cmd.push_pend = 1'b1;
                    cmd.set_pend  = 1'b1;
                    cmd.take_quot = 1'b1;
                end
            dpf_pkg::ST_FINISH:
                if (status.out_free && status.pend_valid)
                begin
                    cmd.push_pend  = 1'b1;
                    cmd.push_last  = !status.n_gt1;
                    cmd.clear_pend = 1'b1;
                end
            dpf_pkg::ST_EMIT_REM:
                if (status.out_free)
                begin
                    cmd.push_rem  = 1'b1;
                    cmd.push_last = 1'b1;
                end
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dpf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/distinct_prime_factors_top.sv
// distinct prime factors by trial division: one value in, one or more factor beats out
// one value is worked on at a time; each trial divisor runs on the single bit-serial
// divider, and each division that succeeds is repeated with the same divisor
// worst case for 32 bits is about 46341 trials; 0, 1 and -1 give their single
// none-found beat from the check state once the output register is free
// reset clears the controller and the output register; no memory needs clearing
`timescale 1ns / 1ps

module distinct_prime_factors_top #(
    parameter int VALUE_WIDTH = dpf_pkg::VALUE_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    dpf_in_if.sink    in_ch,
    dpf_out_if.source out_ch
);

    dpf_pkg::cmd_t    cmd;
    dpf_pkg::status_t status;

    dpf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .status  (status),
        .cmd     (cmd)
    );

    dpf_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .value         (in_ch.value),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_factor    (out_ch.factor),
        .out_last      (out_ch.last),
        .out_none_found(out_ch.none_found)
    );

endmodule
